// ----- design/weekly_onoff_schedule_timer_defines.svh -----
// Assertion macros shared by the weekly on/off schedule timer RTL.
// Depends on nothing; define NO_ASSERTIONS to compile the checks away.
`ifndef WEEKLY_ONOFF_SCHEDULE_TIMER_DEFINES_SVH
`define WEEKLY_ONOFF_SCHEDULE_TIMER_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define WOST_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define WOST_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define WOST_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define WOST_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// ----- design/wost_pkg.sv -----
// Package for the weekly on/off schedule timer: modes, window codes,
// result and queue entry types, and the minutes-of-day helper. No dependencies.
package wost_pkg;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [2:0] MODE_SLEEP     = 3'd0;
  localparam logic [2:0] MODE_WIN_WAIT  = 3'd1;
  localparam logic [2:0] MODE_WIN       = 3'd2;
  localparam logic [2:0] MODE_CNT_WAIT  = 3'd3;
  localparam logic [2:0] MODE_CNT       = 3'd4;
  localparam logic [2:0] MODE_WEEK_WAIT = 3'd5;
  localparam logic [2:0] MODE_WEEK      = 3'd6;

  localparam logic [1:0] SIG_KEEP  = 2'd0;
  localparam logic [1:0] SIG_START = 2'd1;
  localparam logic [1:0] SIG_STOP  = 2'd2;

  localparam logic [10:0] MINS_PER_HOUR = 11'd60;

  typedef struct packed {
    logic       action_valid;
    logic [7:0] action_code;
    logic       sleeping;
  } result_t;

  typedef struct packed {
    logic    two;
    result_t r0;
    result_t r1;
  } entry_t;

  function automatic logic [10:0] minutes_of_day(input logic [4:0] hour,
                                                 input logic [5:0] minute);
    minutes_of_day = {6'd0, hour} * MINS_PER_HOUR + {5'd0, minute};
  endfunction

  function automatic logic [1:0] window_signal(input logic [10:0] start_m,
                                               input logic [10:0] end_m,
                                               input logic [10:0] now_m);
    window_signal = SIG_KEEP;
    if (start_m < end_m) begin
      if (now_m >= end_m) begin
        window_signal = SIG_STOP;
      end else if (now_m >= start_m) begin
        window_signal = SIG_START;
      end
    end
  endfunction

endpackage

// ----- design/wost_ifs.sv -----
// Channel interfaces of the schedule timer: request input and result output.
// Depends on nothing but plain logic types.
interface wost_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [4:0] now_hour;
  logic [5:0] now_minute;
  logic [2:0] now_weekday;
  logic [2:0] arm_mode;
  logic [4:0] arm_start_hour;
  logic [5:0] arm_start_minute;
  logic [4:0] arm_end_hour;
  logic [5:0] arm_end_minute;
  logic [7:0] arm_day_mask;
  logic [7:0] arm_on_action;
  logic [7:0] arm_off_action;

  modport source (output valid, command, now_hour, now_minute, now_weekday, arm_mode,
                  arm_start_hour, arm_start_minute, arm_end_hour, arm_end_minute,
                  arm_day_mask, arm_on_action, arm_off_action, input ready);
  modport sink (input valid, command, now_hour, now_minute, now_weekday, arm_mode,
                arm_start_hour, arm_start_minute, arm_end_hour, arm_end_minute,
                arm_day_mask, arm_on_action, arm_off_action, output ready);
endinterface

interface wost_out_if;
  logic       valid;
  logic       ready;
  logic       action_valid;
  logic [7:0] action_code;
  logic       sleeping;
  logic       last;

  modport source (output valid, action_valid, action_code, sleeping, last, input ready);
  modport sink (input valid, action_valid, action_code, sleeping, last, output ready);
endinterface

// ----- design/wost_front.sv -----
// Front end: accepts requests, keeps the schedule state and works out the
// results of each tick as one queue entry. Depends on wost_pkg and wost_ifs.
module wost_front (
  input  logic             clk,
  input  logic             rst_n,
  wost_in_if.sink          in_ch,
  input  logic             q_full,
  output logic             q_push,
  output wost_pkg::entry_t q_data
);
  import wost_pkg::*;

  logic [2:0]  mode_r, mode_nxt;
  logic [10:0] start_r, start_nxt;
  logic [10:0] end_r, end_nxt;
  logic [7:0]  mask_r, mask_nxt;
  logic [7:0]  on_r, on_nxt;
  logic [7:0]  off_r, off_nxt;

  logic        accept;
  logic [10:0] now_m;
  logic [1:0]  sig;
  logic        day_on;
  result_t     res_on, res_off, res_none;
  entry_t      ent;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;

  assign now_m  = minutes_of_day(in_ch.now_hour, in_ch.now_minute);
  assign sig    = window_signal(start_r, end_r, now_m);
  assign day_on = mask_r[in_ch.now_weekday];

  assign res_on   = '{action_valid: 1'b1, action_code: on_r, sleeping: 1'b0};
  assign res_off  = '{action_valid: 1'b1, action_code: off_r, sleeping: 1'b0};
  assign res_none = '{action_valid: 1'b0, action_code: 8'd0, sleeping: 1'b0};

  always_comb begin
    mode_nxt  = mode_r;
    start_nxt = start_r;
    end_nxt   = end_r;
    mask_nxt  = mask_r;
    on_nxt    = on_r;
    off_nxt   = off_r;
    ent.two   = 1'b0;
    ent.r0    = res_none;
    ent.r1    = res_none;
    case (mode_r)
      MODE_SLEEP: begin
        ent.r0.sleeping = 1'b1;
      end
      MODE_WIN_WAIT: begin
        if (sig == SIG_START) begin
          ent.r0   = res_on;
          mode_nxt = MODE_WIN;
        end else if (sig == SIG_STOP) begin
          ent.r0   = res_off;
          mode_nxt = MODE_SLEEP;
        end
      end
      MODE_WIN: begin
        if (sig == SIG_STOP) begin
          ent.r0   = res_off;
          mode_nxt = MODE_SLEEP;
        end
      end
      MODE_CNT_WAIT: begin
        // The start action goes out at once and the end test follows in the same tick.
        ent.r0   = res_on;
        mode_nxt = MODE_CNT;
        if (now_m >= end_r) begin
          ent.two   = 1'b1;
          ent.r1    = res_off;
          start_nxt = '0;
          end_nxt   = '0;
          mode_nxt  = MODE_SLEEP;
        end
      end
      MODE_CNT: begin
        if (now_m >= end_r) begin
          ent.r0    = res_off;
          start_nxt = '0;
          end_nxt   = '0;
          mode_nxt  = MODE_SLEEP;
        end
      end
      MODE_WEEK_WAIT: begin
        if (day_on && sig == SIG_START) begin
          ent.r0   = res_on;
          mode_nxt = MODE_WEEK;
        end else begin
          ent.r0 = res_off;
        end
      end
      MODE_WEEK: begin
        if (!day_on || sig == SIG_STOP) begin
          ent.r0   = res_off;
          mode_nxt = MODE_WEEK_WAIT;
        end
      end
      default: begin
      end
    endcase
    if (in_ch.command) begin
      mode_nxt  = in_ch.arm_mode;
      start_nxt = minutes_of_day(in_ch.arm_start_hour, in_ch.arm_start_minute);
      end_nxt   = minutes_of_day(in_ch.arm_end_hour, in_ch.arm_end_minute);
      mask_nxt  = in_ch.arm_day_mask;
      on_nxt    = in_ch.arm_on_action;
      off_nxt   = in_ch.arm_off_action;
    end
  end

  assign q_push = accept && !in_ch.command;
  assign q_data = ent;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_SLEEP;
      start_r <= '0;
      end_r   <= '0;
      mask_r  <= '0;
      on_r    <= '0;
      off_r   <= '0;
    end else if (accept) begin
      mode_r  <= mode_nxt;
      start_r <= start_nxt;
      end_r   <= end_nxt;
      mask_r  <= mask_nxt;
      on_r    <= on_nxt;
      off_r   <= off_nxt;
    end
  end

endmodule

// ----- design/wost_queue.sv -----
// Short queue of tick results between the front and back ends.
// Depends on wost_pkg and the assertion macro header.
`include "weekly_onoff_schedule_timer_defines.svh"

module wost_queue #(
  parameter int DEPTH = wost_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  wost_pkg::entry_t push_data,
  input  logic             pop,
  output wost_pkg::entry_t head,
  output logic             full,
  output logic             empty
);
  import wost_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  entry_t        mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  `WOST_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, count_r <= CW'(DEPTH), "queue overfilled")
  `WOST_ASSERT_NXT(a_push_grows, clk, rst_n, do_push && !do_pop, count_r == $past(count_r) + 1'b1, "queue count lost a push")
  `WOST_ASSERT_IMP(a_full_empty, clk, rst_n, 1'b1, !(full && empty), "queue full and empty at once")

endmodule

// ----- design/wost_back.sv -----
// Back end: drains queue entries and presents one or two results each.
// Depends on wost_pkg, wost_ifs and the assertion macro header.
`include "weekly_onoff_schedule_timer_defines.svh"

module wost_back (
  input  logic             clk,
  input  logic             rst_n,
  input  wost_pkg::entry_t head,
  input  logic             q_empty,
  output logic             q_pop,
  wost_out_if.source       out_ch
);
  import wost_pkg::*;

  logic    phase_r, phase_nxt;
  logic    is_last;
  logic    accept;
  result_t res;

  assign res     = phase_r ? head.r1 : head.r0;
  assign is_last = !head.two || phase_r;
  assign accept  = out_ch.valid && out_ch.ready;
  assign q_pop   = accept && is_last;

  assign out_ch.valid        = !q_empty;
  assign out_ch.action_valid = res.action_valid;
  assign out_ch.action_code  = res.action_code;
  assign out_ch.sleeping     = res.sleeping;
  assign out_ch.last         = is_last;

  always_comb begin
    phase_nxt = phase_r;
    if (accept) begin
      phase_nxt = !is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
    end
  end

  `WOST_ASSERT_IMP(a_phase_two, clk, rst_n, phase_r, !q_empty && head.two, "second result without a two-result entry")
  `WOST_ASSERT_IMP(a_second_acts, clk, rst_n, phase_r, head.r1.action_valid, "second result carries no action")
  `WOST_ASSERT_NXT(a_stall_hold, clk, rst_n, out_ch.valid && !out_ch.ready, out_ch.valid && $stable(out_ch.action_code) && $stable(out_ch.last), "stalled result changed")

endmodule

// ----- design/weekly_onoff_schedule_timer.sv -----
// Top level of the weekly on/off schedule timer.
// Depends on wost_pkg, wost_ifs, wost_front, wost_queue and wost_back.
//
// Usage: requests arrive on in_ch (valid/ready). A request with command set
// arms the schedule (mode, window start and end, day mask, on and off action
// codes) and produces no result. A request with command clear is a tick with
// the current hour, minute and weekday; it yields one or two results on
// out_ch, the final one of each tick flagged by last.
// A tick is written into the queue; its first result shows at the queue head
// once older results are taken. Throughput: one request per cycle while the queue
// is not full; a tick with two results holds the result port until both are taken.
// The single queue read port gives one result a cycle while out_ch.ready is high.
// The front end decides every tick in the cycle it is accepted, so
// back-to-back ticks see the state that the previous one left.
// Stalls: when out_ch.ready is low, results wait in the queue; in_ch.ready
// drops only once the queue is full, and arm requests are held too then.
// Reset (rst_n low, synchronous) returns the timer to sleep mode with all
// times, mask and action codes at zero and empties the queue.
module weekly_onoff_schedule_timer #(
  parameter int QDEPTH = wost_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  wost_in_if.sink    in_ch,
  wost_out_if.source out_ch
);
  import wost_pkg::*;

  // Entry handed from the front end to the queue, and the queue head to the back end.
  entry_t push_data;
  entry_t head;
  logic   push, pop, full, empty;

  // Front end: classifies each request and updates the schedule state.
  wost_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (full),
    .q_push (push),
    .q_data (push_data)
  );

  // The queue decouples a stalled receiver from the request side.
  wost_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .full      (full),
    .empty     (empty)
  );

  // Back end: serialises the one or two results of each tick.
  wost_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .head    (head),
    .q_empty (empty),
    .q_pop   (pop),
    .out_ch  (out_ch)
  );

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for weekly_onoff_schedule_timer: directed and random arm and tick requests.
// Depends on wost_pkg, the wost_in_if and wost_out_if interfaces and the timer RTL.

module tb_top;
  import wost_pkg::*;

  // The package names seven modes, codes 0 to 6; code 7 is the inert mode.
  localparam logic [2:0] MODE_INERT = 3'd7;
  localparam logic       CMD_TICK   = 1'b0;
  localparam logic       CMD_ARM    = 1'b1;

  localparam int RANDOM_REQUESTS = 1550;
  localparam int SETTLE_CYCLES   = 10;

  // One request as it appears on the input channel.
  typedef struct packed {
    logic       command;
    logic [4:0] now_hour;
    logic [5:0] now_minute;
    logic [2:0] now_weekday;
    logic [2:0] arm_mode;
    logic [4:0] arm_start_hour;
    logic [5:0] arm_start_minute;
    logic [4:0] arm_end_hour;
    logic [5:0] arm_end_minute;
    logic [7:0] arm_day_mask;
    logic [7:0] arm_on_action;
    logic [7:0] arm_off_action;
  } sched_req_t;

  // One result as it appears on the output channel.
  typedef struct packed {
    logic       action_valid;
    logic [7:0] action_code;
    logic       sleeping;
    logic       last;
  } sched_res_t;

  logic clk = 1'b0;
  logic rst_n;

  wost_in_if  req_if ();
  wost_out_if res_if ();

  weekly_onoff_schedule_timer dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (req_if),
    .out_ch (res_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Our own copy of the armed schedule, advanced as each request is accepted.
  logic [2:0]  sch_mode;
  logic [10:0] sch_start;
  logic [10:0] sch_end;
  logic [7:0]  sch_mask;
  logic [7:0]  sch_on;
  logic [7:0]  sch_off;

  // Results still owed by the block, oldest first.
  sched_res_t pending_actions[$];

  bit idle_on = 1'b1;
  int out_hold = 0;
  int res_seen = 0;
  int n_errors = 0;
  int n_sent = 0;
  int n_arms = 0;
  int n_ticks = 0;
  int n_double = 0;
  int n_results = 0;

  // ---------------------------------------------------------------------------
  // Schedule predictor
  // ---------------------------------------------------------------------------

  // Hours and minutes are taken as given; even 31:63 fits in eleven bits.
  function automatic logic [10:0] clock_minutes(logic [4:0] hour, logic [5:0] minute);
    return {6'd0, hour} * MINS_PER_HOUR + {5'd0, minute};
  endfunction

  // The window only means anything when it starts before it ends. Past the
  // end is a stop, otherwise past the start is a start; all else keeps.
  function automatic logic [1:0] span_state(logic [10:0] now_m);
    if (sch_start < sch_end) begin
      if (now_m >= sch_end) begin
        return SIG_STOP;
      end
      if (now_m >= sch_start) begin
        return SIG_START;
      end
    end
    return SIG_KEEP;
  endfunction

  function automatic sched_res_t issue(logic [7:0] code);
    return '{action_valid: 1'b1, action_code: code, sleeping: 1'b0, last: 1'b0};
  endfunction

  // Works out what one accepted request does to the schedule and which
  // results it owes; those are appended to pending_actions.
  task automatic predict_schedule(sched_req_t r);
    sched_res_t  acts[$];
    logic [10:0] now_m;
    logic        day_on;
    logic [1:0]  span;
    if (r.command == CMD_ARM) begin
      // An arm request replaces the whole schedule and gives no result.
      sch_mode  = r.arm_mode;
      sch_start = clock_minutes(r.arm_start_hour, r.arm_start_minute);
      sch_end   = clock_minutes(r.arm_end_hour, r.arm_end_minute);
      sch_mask  = r.arm_day_mask;
      sch_on    = r.arm_on_action;
      sch_off   = r.arm_off_action;
      n_arms++;
      return;
    end
    n_ticks++;
    now_m  = clock_minutes(r.now_hour, r.now_minute);
    day_on = sch_mask[r.now_weekday];
    span   = span_state(now_m);
    case (sch_mode)
      MODE_SLEEP: begin
        acts.push_back('{action_valid: 1'b0, action_code: 8'h00, sleeping: 1'b1, last: 1'b0});
      end
      MODE_WIN_WAIT: begin
        // Having just started, the window cannot also stop on this tick.
        if (span == SIG_START) begin
          acts.push_back(issue(sch_on));
          sch_mode = MODE_WIN;
        end else if (span == SIG_STOP) begin
          acts.push_back(issue(sch_off));
          sch_mode = MODE_SLEEP;
        end
      end
      MODE_WIN: begin
        if (span == SIG_STOP) begin
          acts.push_back(issue(sch_off));
          sch_mode = MODE_SLEEP;
        end
      end
      MODE_CNT_WAIT, MODE_CNT: begin
        // The waiting countdown starts at once and then falls through to the
        // end test, so one tick may give both actions.
        if (sch_mode == MODE_CNT_WAIT) begin
          acts.push_back(issue(sch_on));
          sch_mode = MODE_CNT;
        end
        if (now_m >= sch_end) begin
          acts.push_back(issue(sch_off));
          sch_start = '0;
          sch_end   = '0;
          sch_mode  = MODE_SLEEP;
        end
      end
      MODE_WEEK_WAIT: begin
        // Every tick that does not open the window repeats the off action.
        if (day_on && span == SIG_START) begin
          acts.push_back(issue(sch_on));
          sch_mode = MODE_WEEK;
        end else begin
          acts.push_back(issue(sch_off));
        end
      end
      MODE_WEEK: begin
        if (!day_on || span == SIG_STOP) begin
          acts.push_back(issue(sch_off));
          sch_mode = MODE_WEEK_WAIT;
        end
      end
      default: begin
      end
    endcase
    if (acts.size() == 0) begin
      acts.push_back('{action_valid: 1'b0, action_code: 8'h00, sleeping: 1'b0, last: 1'b0});
    end
    acts[acts.size() - 1].last = 1'b1;
    if (acts.size() == 2) begin
      n_double++;
    end
    foreach (acts[i]) begin
      pending_actions.push_back(acts[i]);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Request builders
  // ---------------------------------------------------------------------------

  // Every field is drawn over its full width, so fields that a request does
  // not use still toggle, and hours and minutes go beyond a real clock.
  function automatic sched_req_t random_request();
    return {$urandom(), $urandom()};
  endfunction

  function automatic sched_req_t tick_req(logic [4:0] hour, logic [5:0] minute,
                                          logic [2:0] weekday);
    sched_req_t r;
    r             = random_request();
    r.command     = CMD_TICK;
    r.now_hour    = hour;
    r.now_minute  = minute;
    r.now_weekday = weekday;
    return r;
  endfunction

  function automatic sched_req_t arm_req(logic [2:0] mode, logic [4:0] sh, logic [5:0] sm,
                                         logic [4:0] eh, logic [5:0] em, logic [7:0] mask,
                                         logic [7:0] on_code, logic [7:0] off_code);
    sched_req_t r;
    r                  = random_request();
    r.command          = CMD_ARM;
    r.arm_mode         = mode;
    r.arm_start_hour   = sh;
    r.arm_start_minute = sm;
    r.arm_end_hour     = eh;
    r.arm_end_minute   = em;
    r.arm_day_mask     = mask;
    r.arm_on_action    = on_code;
    r.arm_off_action   = off_code;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Request channel driver
  // ---------------------------------------------------------------------------

  task automatic put_fields(sched_req_t r);
    req_if.command          <= r.command;
    req_if.now_hour         <= r.now_hour;
    req_if.now_minute       <= r.now_minute;
    req_if.now_weekday      <= r.now_weekday;
    req_if.arm_mode         <= r.arm_mode;
    req_if.arm_start_hour   <= r.arm_start_hour;
    req_if.arm_start_minute <= r.arm_start_minute;
    req_if.arm_end_hour     <= r.arm_end_hour;
    req_if.arm_end_minute   <= r.arm_end_minute;
    req_if.arm_day_mask     <= r.arm_day_mask;
    req_if.arm_on_action    <= r.arm_on_action;
    req_if.arm_off_action   <= r.arm_off_action;
  endtask

  // Presents one request after a random gap and returns once it has been
  // taken. With no gap, valid simply stays high into the next request, so it
  // is never lowered and raised again at the same edge.
  task automatic send_request(sched_req_t r);
    int gap;
    gap = idle_on ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      @(negedge clk);
      req_if.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    put_fields(r);
    req_if.valid <= 1'b1;
    @(posedge clk);
    while (!req_if.ready) begin
      @(posedge clk);
    end
    predict_schedule(r);
    n_sent++;
  endtask

  // Stops sending and waits until the block has delivered everything it owes.
  task automatic hold_until_drained();
    @(negedge clk);
    req_if.valid <= 1'b0;
    while (pending_actions.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result channel: back-pressure and checking
  // ---------------------------------------------------------------------------

  // After each result, while idling is on, the sink may hold ready low.
  always @(negedge clk) begin
    if (n_results != res_seen) begin
      res_seen = n_results;
      out_hold = idle_on ? $urandom_range(0, 3) : 0;
    end
    if (out_hold > 0) begin
      res_if.ready <= 1'b0;
      out_hold--;
    end else begin
      res_if.ready <= 1'b1;
    end
  end

  task automatic check_field(string name, logic [7:0] want_v, logic [7:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want_v, got_v);
      n_errors++;
    end
  endtask

  sched_res_t want_res;

  // Each result taken is compared with the oldest one still owed.
  always @(posedge clk) begin
    if (rst_n && res_if.valid && res_if.ready) begin
      if (pending_actions.size() == 0) begin
        $display("%0t ns: unexpected result, expected none, actual valid=%0b code=%0h sleeping=%0b last=%0b",
                 $time, res_if.action_valid, res_if.action_code, res_if.sleeping, res_if.last);
        n_errors++;
      end else begin
        want_res = pending_actions.pop_front();
        check_field("action_valid", 8'(want_res.action_valid), 8'(res_if.action_valid));
        check_field("action_code", want_res.action_code, res_if.action_code);
        check_field("sleeping", 8'(want_res.sleeping), 8'(res_if.sleeping));
        check_field("last", 8'(want_res.last), 8'(res_if.last));
      end
      n_results++;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Straight out of reset the timer sleeps whatever the time of day.
  task automatic test_reset_state();
    send_request(tick_req(5'd31, 6'd63, 3'd7));
    send_request(tick_req(5'd0, 6'd0, 3'd0));
  endtask

  // One-shot window: quiet before the start, on at the start, quiet inside,
  // off at the end. A window already over when first seen goes straight off.
  task automatic test_window_mode();
    send_request(arm_req(MODE_WIN_WAIT, 5'd8, 6'd0, 5'd9, 6'd30, 8'h00, 8'hFF, 8'h00));
    send_request(tick_req(5'd7, 6'd59, 3'd2));
    send_request(tick_req(5'd8, 6'd0, 3'd2));
    send_request(tick_req(5'd9, 6'd29, 3'd2));
    send_request(tick_req(5'd9, 6'd30, 3'd2));
    send_request(arm_req(MODE_WIN_WAIT, 5'd10, 6'd0, 5'd11, 6'd0, 8'hFF, 8'h5A, 8'hA5));
    send_request(tick_req(5'd12, 6'd0, 3'd4));
  endtask

  // Countdown: past its end on the first tick it gives both actions at once
  // and clears the stored times; otherwise on now, off at the end.
  task automatic test_countdown();
    send_request(arm_req(MODE_CNT_WAIT, 5'd0, 6'd0, 5'd0, 6'd30, 8'h0F, 8'h11, 8'h22));
    send_request(tick_req(5'd1, 6'd0, 3'd1));
    send_request(arm_req(MODE_CNT_WAIT, 5'd0, 6'd0, 5'd20, 6'd0, 8'hF0, 8'h33, 8'h44));
    send_request(tick_req(5'd10, 6'd0, 3'd5));
    send_request(tick_req(5'd20, 6'd0, 3'd5));
  endtask

  // Weekly window gated on weekday 7 only: disabled days repeat the off
  // action, the enabled day opens it, and leaving the day closes it again.
  task automatic test_weekly();
    send_request(arm_req(MODE_WEEK_WAIT, 5'd6, 6'd0, 5'd7, 6'd0, 8'h80, 8'h01, 8'h02));
    send_request(tick_req(5'd6, 6'd30, 3'd1));
    send_request(tick_req(5'd6, 6'd30, 3'd7));
    send_request(tick_req(5'd6, 6'd45, 3'd7));
    send_request(tick_req(5'd6, 6'd50, 3'd0));
  endtask

  // The inert code does nothing, a window that does not start before its end
  // never fires, and out-of-range hours and minutes are taken literally.
  task automatic test_inert_and_odd_windows();
    send_request(arm_req(MODE_INERT, 5'd1, 6'd0, 5'd2, 6'd0, 8'hFF, 8'hAA, 8'hBB));
    send_request(tick_req(5'd1, 6'd30, 3'd3));
    send_request(arm_req(MODE_WIN_WAIT, 5'd9, 6'd0, 5'd9, 6'd0, 8'h55, 8'h12, 8'h34));
    send_request(tick_req(5'd9, 6'd0, 3'd6));
    send_request(arm_req(MODE_WIN, 5'd23, 6'd59, 5'd31, 6'd63, 8'hAA, 8'hC3, 8'h3C));
    send_request(tick_req(5'd31, 6'd63, 3'd7));
    send_request(tick_req(5'd12, 6'd34, 3'd6));
  endtask

  // Mostly well-formed schedules: an arm followed by a handful of ticks aimed
  // at the minutes either side of the start and the end, so every mode walks
  // through its transitions. One pick in eight is a lone noise request. Idling is
  // switched off for one stretch in four, and half way through the sender
  // waits for the block to drain.
  task automatic test_random_schedules();
    sched_req_t  r;
    logic [10:0] s_m;
    logic [10:0] e_m;
    logic [10:0] t_m;
    logic [2:0]  mode_pick;
    logic [7:0]  mask_pick;
    int          pick;
    int          base;
    bit          drained;
    base    = n_sent;
    drained = 1'b0;
    while (n_sent - base < RANDOM_REQUESTS) begin
      idle_on = (((n_sent - base) / 120) % 4) != 3;
      if (!drained && n_sent - base >= RANDOM_REQUESTS / 2) begin
        hold_until_drained();
        drained = 1'b1;
      end
      if ($urandom_range(0, 7) == 0) begin
        send_request(random_request());
      end else begin
        pick = $urandom_range(0, 15);
        if (pick < 14) begin
          mode_pick = 3'(1 + pick % 6);
        end else if (pick == 14) begin
          mode_pick = MODE_SLEEP;
        end else begin
          mode_pick = MODE_INERT;
        end
        s_m = 11'($urandom_range(0, 1438));
        if ($urandom_range(0, 9) != 0) begin
          e_m = 11'($urandom_range(s_m + 1, 1439));
        end else begin
          e_m = 11'($urandom_range(0, 1439));
        end
        case ($urandom_range(0, 3))
          0: mask_pick = 8'hFF;
          1: mask_pick = 8'h00;
          default: mask_pick = 8'($urandom());
        endcase
        send_request(arm_req(mode_pick, 5'(s_m / 60), 6'(s_m % 60), 5'(e_m / 60),
                             6'(e_m % 60), mask_pick, 8'($urandom()), 8'($urandom())));
        repeat ($urandom_range(2, 8)) begin
          case ($urandom_range(0, 5))
            0: t_m = (s_m == 11'd0) ? s_m : s_m - 11'd1;
            1: t_m = s_m;
            2: t_m = (e_m == 11'd0) ? e_m : e_m - 11'd1;
            3: t_m = e_m;
            4: t_m = 11'($urandom_range(s_m, e_m));
            default: t_m = 11'($urandom_range(0, 1439));
          endcase
          r = tick_req(5'(t_m / 60), 6'(t_m % 60), 3'($urandom_range(0, 7)));
          send_request(r);
        end
      end
    end
    idle_on = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_n     = 1'b0;
    sch_mode  = MODE_SLEEP;
    sch_start = '0;
    sch_end   = '0;
    sch_mask  = '0;
    sch_on    = '0;
    sch_off   = '0;
    req_if.valid <= 1'b0;
    put_fields('0);
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_state();
    test_window_mode();
    test_countdown();
    test_weekly();
    test_inert_and_odd_windows();
    test_random_schedules();

    hold_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Covered %0d arm and %0d tick requests over every mode and the inert code.",
             n_arms, n_ticks);
    $display("Checked %0d results, %0d of the ticks giving two actions at once.",
             n_results, n_double);
    if (n_errors == 0) begin
      $display("weekly_onoff_schedule_timer verification clean");
    end else begin
      $display("weekly_onoff_schedule_timer verification failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run with every gap and stall at
  // its longest and every tick giving two results.
  initial begin
    #2_000_000;
    $display("Timed out with %0d results still owed.", pending_actions.size());
    $display("weekly_onoff_schedule_timer verification failed");
    $finish;
  end

endmodule
